>>> hw/rtl/cfa_pkg.sv
// shared types and codes for the contiguous file allocator
`default_nettype none
package cfa_pkg;

	localparam logic [1:0] OP_STORE  = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_RSVD   = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EXISTS   = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOSPACE  = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam logic [7:0] BLK_TOTAL_RST = 8'd98;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] file_key;
		logic [17:0] byte_len;
	} cfa_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  first_blk;
		logic [17:0] file_bytes;
		logic [4:0]  slot;
	} cfa_result_t;

	// one directory entry
	typedef struct packed {
		logic [63:0] key;
		logic [6:0]  start;
		logic [17:0] bytes;
	} cfa_entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/contiguous_file_allocator.sv
// top level of the contiguous file allocator: control sequencer and registers
//
// channel   | handshake            | payload
// ----------+----------------------+----------------------------
// command   | start, busy          | cmd (opcode, file_key, byte_len)
// result    | result_valid strobe  | result (status, first_blk, file_bytes, slot)
// config    | cfg_valid, cfg_ready | cfg_data (usable block total)
//
// lookup and delete do one directory read and one compare per slot
// through the single read port of the directory memory
// store then clears the occupancy memory, marks the blocks of each used slot
// from its directory entry and scans the blocks first-fit for a free run
// reset clears the used flags and the sequencer and sets the block total to 98
// results show for one cycle on result_valid; the receiver cannot stall
`default_nettype none
module contiguous_file_allocator #(
	parameter int SLOTS       = 32,
	parameter int BLOCKS      = 128,
	parameter int BLOCK_BYTES = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire cfa_pkg::cfa_cmd_t cmd,
	output logic                   result_valid,
	output cfa_pkg::cfa_result_t   result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data
);
	import cfa_pkg::*;

	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SCW = $clog2(SLOTS + 1);
	localparam int AW  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int BCW = $clog2(BLOCKS + 1);
	localparam int LW  = 19;	// block counts for sizes up to 2^18 bytes

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_KRD  = 4'd1;
	localparam logic [3:0] S_KCMP = 4'd2;
	localparam logic [3:0] S_CLR  = 4'd3;
	localparam logic [3:0] S_MRD  = 4'd4;
	localparam logic [3:0] S_MGET = 4'd5;
	localparam logic [3:0] S_MARK = 4'd6;
	localparam logic [3:0] S_SRD  = 4'd7;
	localparam logic [3:0] S_SCHK = 4'd8;

	logic [3:0]     state_q;
	logic [7:0]     blk_total_q;
	logic [SLOTS-1:0] used_q;
	cfa_cmd_t       cmd_q;
	logic [SCW-1:0] sc_q;		// slot walk counter
	logic [BCW-1:0] bc_q;		// block walk counter
	logic [BCW-1:0] usable_q;
	logic [SW-1:0]  free_q;
	logic           free_ok_q;
	logic [LW-1:0]  need_q;
	logic [LW-1:0]  streak_q;
	logic [LW-1:0]  len_q;
	logic [LW-1:0]  k_q;
	logic [6:0]     mstart_q;

	cfa_entry_t     dir_rd;
	cfa_entry_t     dir_wdata;
	logic           dir_we, dir_re;
	logic [SW-1:0]  dir_raddr;
	logic           map_we, map_wd, map_re, map_rd;
	logic [AW-1:0]  map_waddr;
	logic [LW-1:0]  mark_pos;
	logic [12:0]    bc_ext;
	logic [SW-1:0]  sidx;
	logic [LW-1:0]  streak_inc;
	logic [LW-1:0]  bc_wide;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign sidx      = sc_q[SW-1:0];
	assign mark_pos  = LW'(mstart_q) + k_q;
	assign bc_ext    = {5'd0, blk_total_q};
	assign streak_inc = streak_q + LW'(1);
	assign bc_wide   = LW'(bc_q);

	cfa_dir #(.SLOTS(SLOTS), .SW(SW)) u_dir (
		.clk(clk), .wr_en(dir_we), .wr_addr(free_q), .wr_data(dir_wdata),
		.rd_en(dir_re), .rd_addr(dir_raddr), .rd_data(dir_rd)
	);

	cfa_map #(.BLOCKS(BLOCKS), .AW(AW)) u_map (
		.clk(clk), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wd),
		.rd_en(map_re), .rd_addr(bc_q[AW-1:0]), .rd_data(map_rd)
	);

	// memory port control
	always_comb begin
		dir_re    = 1'b0;
		dir_raddr = sidx;
		dir_we    = 1'b0;
		dir_wdata.key   = cmd_q.file_key;
		dir_wdata.start = 7'(bc_wide - streak_q);
		dir_wdata.bytes = cmd_q.byte_len;
		map_we    = 1'b0;
		map_wd    = 1'b0;
		map_waddr = bc_q[AW-1:0];
		map_re    = 1'b0;
		unique case (state_q)
			S_KRD: begin
				dir_re = (sc_q != SCW'(SLOTS));
			end
			S_CLR: begin
				map_we = (bc_q != BCW'(BLOCKS));
			end
			S_MRD: begin
				dir_re = (sc_q != SCW'(SLOTS)) && used_q[sidx];
			end
			S_MARK: begin
				map_waddr = mark_pos[AW-1:0];
				map_wd    = 1'b1;
				map_we    = (k_q != len_q) && (mark_pos < LW'(usable_q));
			end
			S_SRD: begin
				map_re = (bc_q != usable_q);
			end
			S_SCHK: begin
				dir_we = !map_rd && (streak_inc == need_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			blk_total_q   <= BLK_TOTAL_RST;
			used_q        <= '0;
			result_valid  <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				blk_total_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q     <= cmd;
						sc_q      <= '0;
						free_ok_q <= 1'b0;
						free_q    <= '0;
						// ceil(size / block size), zero bytes needs zero blocks
						need_q    <= LW'((LW'(cmd.byte_len) + LW'(BLOCK_BYTES - 1))
							/ BLOCK_BYTES);
						usable_q  <= (bc_ext > 13'(BLOCKS)) ? BCW'(BLOCKS) : BCW'(bc_ext);
						if (cmd.opcode == OP_STORE || cmd.opcode == OP_LOOKUP
							|| cmd.opcode == OP_DELETE) begin
							state_q <= S_KRD;
						end else begin
							result_valid <= 1'b1;
							result       <= '{ST_NOTFOUND, 7'd0, 18'd0, 5'd0};
						end
					end
				end
				// key search, one slot per read and compare
				S_KRD: begin
					if (sc_q == SCW'(SLOTS)) begin
						if (cmd_q.opcode != OP_STORE) begin
							result_valid <= 1'b1;
							result       <= '{ST_NOTFOUND, 7'd0, 18'd0, 5'd0};
							state_q      <= S_IDLE;
						end else if (!free_ok_q) begin
							result_valid <= 1'b1;
							result       <= '{ST_FULL, 7'd0, 18'd0, 5'd0};
							state_q      <= S_IDLE;
						end else begin
							bc_q    <= '0;
							state_q <= S_CLR;
						end
					end else begin
						state_q <= S_KCMP;
					end
				end
				S_KCMP: begin
					if (used_q[sidx] && dir_rd.key == cmd_q.file_key) begin
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
						if (cmd_q.opcode == OP_STORE) begin
							result <= '{ST_EXISTS, 7'd0, 18'd0, 5'd0};
						end else begin
							result <= '{ST_OK, dir_rd.start, dir_rd.bytes, 5'(sidx)};
							if (cmd_q.opcode == OP_DELETE) begin
								used_q[sidx] <= 1'b0;
							end
						end
					end else begin
						// remember the lowest free slot on the way
						if (!used_q[sidx] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q    <= sidx;
						end
						sc_q    <= sc_q + SCW'(1);
						state_q <= S_KRD;
					end
				end
				// clear the occupancy memory
				S_CLR: begin
					if (bc_q == BCW'(BLOCKS)) begin
						sc_q    <= '0;
						state_q <= S_MRD;
					end else begin
						bc_q <= bc_q + BCW'(1);
					end
				end
				// mark the blocks of every used entry that lie below the usable block count
				S_MRD: begin
					if (sc_q == SCW'(SLOTS)) begin
						bc_q     <= '0;
						streak_q <= '0;
						state_q  <= S_SRD;
					end else if (!used_q[sidx]) begin
						sc_q <= sc_q + SCW'(1);
					end else begin
						state_q <= S_MGET;
					end
				end
				S_MGET: begin
					mstart_q <= dir_rd.start;
					len_q    <= LW'((LW'(dir_rd.bytes) + LW'(BLOCK_BYTES - 1)) / BLOCK_BYTES);
					k_q      <= '0;
					state_q  <= S_MARK;
				end
				S_MARK: begin
					if (k_q == len_q || mark_pos >= LW'(usable_q)) begin
						sc_q    <= sc_q + SCW'(1);
						state_q <= S_MRD;
					end else begin
						k_q <= k_q + LW'(1);
					end
				end
				// first-fit scan
				S_SRD: begin
					if (bc_q == usable_q) begin
						result_valid <= 1'b1;
						result       <= '{ST_NOSPACE, 7'd0, 18'd0, 5'd0};
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_SCHK;
					end
				end
				S_SCHK: begin
					if (!map_rd && streak_inc == need_q) begin
						used_q[free_q] <= 1'b1;
						result_valid   <= 1'b1;
						result         <= '{ST_OK, dir_wdata.start, cmd_q.byte_len,
							5'(free_q)};
						state_q        <= S_IDLE;
					end else begin
						streak_q <= map_rd ? '0 : streak_inc;
						bc_q     <= bc_q + BCW'(1);
						state_q  <= S_SRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cfa_dir.sv
// directory memory: key, start block and byte size per slot
`default_nettype none
module cfa_dir #(
	parameter int SLOTS = 32,
	parameter int SW    = 5
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [SW-1:0]       wr_addr,
	input  wire cfa_pkg::cfa_entry_t wr_data,
	input  wire logic                rd_en,
	input  wire logic [SW-1:0]       rd_addr,
	output cfa_pkg::cfa_entry_t      rd_data
);
	import cfa_pkg::*;

	cfa_entry_t mem_q [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cfa_map.sv
// block occupancy memory, one bit per data block
`default_nettype none
module cfa_map #(
	parameter int BLOCKS = 128,
	parameter int AW     = 7
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic          wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic               rd_data
);
	logic mem_q [BLOCKS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the contiguous file allocator
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import cfa_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cfa_cmd_t    cmd;
	logic        result_valid;
	cfa_result_t result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	contiguous_file_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	localparam int SLOTS       = 32;
	localparam int BLOCKS      = 128;
	localparam int BLOCK_BYTES = 1024;
	localparam int STALL_LIMIT = 20000;
	localparam int N_RANDOM    = 1440;

	// shadow copy of the directory and the block total register
	logic [63:0] dir_key   [SLOTS];
	logic [6:0]  dir_start [SLOTS];
	logic [17:0] dir_bytes [SLOTS];
	logic        dir_used  [SLOTS];
	logic [7:0]  disk_blocks;

	cfa_result_t pending_results[$];
	logic [63:0] known_keys[$];
	int          errors;
	int          idle_cycles;
	bit          quiet_tail;

	// a directed row: command plus an optional typed-in expectation
	typedef struct {
		cfa_cmd_t    c;
		bit          fixed;
		cfa_result_t r;
	} cmd_row_t;

	function automatic int blk_ceil(logic [17:0] bytes);
		return (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
	endfunction

	function automatic int slot_of_key(logic [63:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (dir_used[i] && dir_key[i] == key)
				return i;
		return -1;
	endfunction

	// works out the result of one command and updates the shadow directory
	function automatic cfa_result_t allocate_or_find(cfa_cmd_t c);
		cfa_result_t r;
		bit          taken[BLOCKS];
		int          usable;
		int          need;
		int          run;
		int          first;
		int          free_slot;
		int          idx;
		r = '0;
		case (c.opcode)
			OP_STORE: begin
				if (slot_of_key(c.file_key) >= 0) begin
					r.status = ST_EXISTS;
					return r;
				end
				free_slot = -1;
				for (int i = 0; i < SLOTS; i++)
					if (!dir_used[i] && free_slot < 0)
						free_slot = i;
				if (free_slot < 0) begin
					r.status = ST_FULL;
					return r;
				end
				usable = (disk_blocks > BLOCKS) ? BLOCKS : int'(disk_blocks);
				for (int b = 0; b < BLOCKS; b++)
					taken[b] = 1'b0;
				for (int i = 0; i < SLOTS; i++)
					if (dir_used[i])
						for (int k = 0; k < blk_ceil(dir_bytes[i]); k++)
							if (int'(dir_start[i]) + k < usable)
								taken[int'(dir_start[i]) + k] = 1'b1;
				need  = blk_ceil(c.byte_len);
				run   = 0;
				first = -1;
				// zero-size store never matches a run of length zero here
				for (int b = 0; b < usable && first < 0; b++) begin
					if (!taken[b]) begin
						run++;
						if (run == need)
							first = b + 1 - need;
					end else begin
						run = 0;
					end
				end
				if (first < 0) begin
					r.status = ST_NOSPACE;
					return r;
				end
				dir_key[free_slot]   = c.file_key;
				dir_start[free_slot] = first[6:0];
				dir_bytes[free_slot] = c.byte_len;
				dir_used[free_slot]  = 1'b1;
				r.status      = ST_OK;
				r.first_blk   = first[6:0];
				r.file_bytes  = c.byte_len;
				r.slot        = free_slot[4:0];
			end
			OP_LOOKUP, OP_DELETE: begin
				idx = slot_of_key(c.file_key);
				if (idx < 0) begin
					r.status = ST_NOTFOUND;
					return r;
				end
				if (c.opcode == OP_DELETE)
					dir_used[idx] = 1'b0;
				r.status      = ST_OK;
				r.first_blk   = dir_start[idx];
				r.file_bytes  = dir_bytes[idx];
				r.slot        = idx[4:0];
			end
			default: r.status = ST_NOTFOUND;
		endcase
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result checker: every strobe must match the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result %p", $time, result);
				errors++;
			end else begin
				cfa_result_t want;
				want = pending_results.pop_front();
				if (result.status !== want.status)
					$display("%0t status expected %0d actual %0d", $time, want.status,
						result.status);
				if (result.first_blk !== want.first_blk)
					$display("%0t first_blk expected %0d actual %0d", $time,
						want.first_blk, result.first_blk);
				if (result.file_bytes !== want.file_bytes)
					$display("%0t file_bytes expected %0d actual %0d", $time,
						want.file_bytes, result.file_bytes);
				if (result.slot !== want.slot)
					$display("%0t slot expected %0d actual %0d", $time, want.slot,
						result.slot);
				if (result !== want)
					errors++;
			end
		end
	end

	// watchdog: cycles without any accepted transaction
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// start stays high into the next command unless an idle burst comes
	task automatic gap_maybe();
		int n;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 8);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// issue one command transaction and queue its expected result
	task automatic issue_cmd(cfa_cmd_t c, bit fixed, cfa_result_t r);
		cfa_result_t model;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model = allocate_or_find(c);
		if (fixed && model !== r) begin
			$display("%0t table row disagrees: expected %p predicted %p", $time, r, model);
			errors++;
		end
		pending_results.push_back(model);
		if (c.opcode == OP_STORE && model.status == ST_OK)
			known_keys.push_back(c.file_key);
		gap_maybe();
	endtask

	// write the block total while idle, after outstanding results have drained
	task automatic write_blk_total(logic [7:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (700) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid   <= 1'b0;
		disk_blocks = v;
	endtask

	function automatic cfa_cmd_t make_cmd(logic [1:0] op, logic [63:0] key, logic [17:0] sz);
		cfa_cmd_t c;
		c.opcode     = op;
		c.file_key   = key;
		c.byte_len   = sz;
		return c;
	endfunction

	function automatic cfa_result_t make_res(logic [2:0] st, logic [6:0] sb,
		logic [17:0] fb, logic [4:0] sl);
		cfa_result_t r;
		r.status      = st;
		r.first_blk   = sb;
		r.file_bytes  = fb;
		r.slot        = sl;
		return r;
	endfunction

	// random key: mostly reuse of stored keys so lookups and deletes hit
	function automatic logic [63:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(0, 99) < 60)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		if ($urandom_range(0, 3) == 0)
			return {$urandom, $urandom};
		return 64'(32'($urandom_range(0, 63)));
	endfunction

	function automatic logic [17:0] pick_size();
		case ($urandom_range(0, 9))
			0:       return 18'($urandom_range(0, 1));
			1:       return 18'($urandom_range(0, 131072));
			2:       return 18'h3FFFF - 18'($urandom_range(0, 3));
			default: return 18'($urandom_range(1, 8192));
		endcase
	endfunction

	initial begin
		cmd_row_t    rows[$];
		cfa_cmd_t    c;
		logic [1:0]  op;
		logic [7:0]  setting[5];
		int          waited;

		errors      = 0;
		idle_cycles = 0;
		quiet_tail  = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		disk_blocks = BLK_TOTAL_RST;
		for (int i = 0; i < SLOTS; i++) begin
			dir_key[i]   = '0;
			dir_start[i] = '0;
			dir_bytes[i] = '0;
			dir_used[i]  = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset block count of 98
		rows.push_back('{make_cmd(OP_LOOKUP, 64'h0, 18'd0), 1,
			make_res(ST_NOTFOUND, 0, 0, 0)});
		rows.push_back('{make_cmd(OP_DELETE, '1, 18'd0), 1,
			make_res(ST_NOTFOUND, 0, 0, 0)});
		rows.push_back('{make_cmd(OP_STORE, 64'h1, 18'd0), 1,
			make_res(ST_NOSPACE, 0, 0, 0)});
		rows.push_back('{make_cmd(OP_STORE, 64'h1, 18'd1), 1,
			make_res(ST_OK, 0, 18'd1, 0)});
		rows.push_back('{make_cmd(OP_STORE, 64'h1, 18'd5), 1,
			make_res(ST_EXISTS, 0, 0, 0)});
		rows.push_back('{make_cmd(OP_STORE, '1, 18'd1024), 1,
			make_res(ST_OK, 7'd1, 18'd1024, 5'd1)});
		rows.push_back('{make_cmd(OP_STORE, 64'h2, 18'd1025), 1,
			make_res(ST_OK, 7'd2, 18'd1025, 5'd2)});
		rows.push_back('{make_cmd(OP_STORE, 64'h3, 18'h3FFFF), 1,
			make_res(ST_NOSPACE, 0, 0, 0)});
		rows.push_back('{make_cmd(OP_STORE, 64'h4, 18'd131072), 1,
			make_res(ST_NOSPACE, 0, 0, 0)});
		rows.push_back('{make_cmd(OP_LOOKUP, '1, 18'h3FFFF), 1,
			make_res(ST_OK, 7'd1, 18'd1024, 5'd1)});
		rows.push_back('{make_cmd(OP_RSVD, 64'h1, 18'd0), 1,
			make_res(ST_NOTFOUND, 0, 0, 0)});
		rows.push_back('{make_cmd(OP_DELETE, 64'h1, 18'd0), 1,
			make_res(ST_OK, 0, 18'd1, 0)});
		rows.push_back('{make_cmd(OP_STORE, 64'h5, 18'd2048), 0, '0});
		rows.push_back('{make_cmd(OP_STORE, 64'h6, 18'd94208), 0, '0});
		rows.push_back('{make_cmd(OP_STORE, 64'h7, 18'd1), 0, '0});
		rows.push_back('{make_cmd(OP_LOOKUP, 64'h7, 18'd0), 0, '0});
		rows.push_back('{make_cmd(OP_DELETE, 64'h6, 18'd0), 0, '0});
		rows.push_back('{make_cmd(OP_STORE, 64'hAAAA_5555_AAAA_5555, 18'h2AAAA), 0, '0});
		rows.push_back('{make_cmd(OP_STORE, 64'h5555_AAAA_5555_AAAA, 18'h15555), 0, '0});
		foreach (rows[i])
			issue_cmd(rows[i].c, rows[i].fixed, rows[i].r);

		// zero-size stores, then stores that fill every free slot and go past catalogue full
		for (int i = 0; i < SLOTS; i++)
			issue_cmd(make_cmd(OP_STORE, 64'h100 + i, 18'd0), 0, '0);
		write_blk_total(8'd255);
		for (int i = 0; i < SLOTS + 1; i++)
			issue_cmd(make_cmd(OP_STORE, 64'h200 + i, 18'd1), 0, '0);

		// random phases over several block counts, extremes included
		setting = '{8'd0, 8'd1, 8'd128, 8'd255, 8'd40};
		for (int p = 0; p < 5; p++) begin
			write_blk_total(setting[p]);
			// clear out part of the directory so stores can land
			for (int i = 0; i < SLOTS; i++)
				if (dir_used[i] && $urandom_range(0, 1))
					issue_cmd(make_cmd(OP_DELETE, dir_key[i], 18'($urandom)), 0, '0);
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				if (p == 4 && n > N_RANDOM / 5 - 60)
					quiet_tail = 1'b1;
				case ($urandom_range(0, 19))
					0:         op = OP_RSVD;
					1, 2, 3:   op = OP_DELETE;
					4, 5, 6,
					7, 8:      op = OP_LOOKUP;
					default:   op = OP_STORE;
				endcase
				c = make_cmd(op, pick_key(), pick_size());
				issue_cmd(c, 0, '0);
			end
		end
		start <= 1'b0;

		waited = 0;
		while (pending_results.size() != 0 && waited < STALL_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (700) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t %0d results never arrived", $time, pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
